[design/line_segment_magnetic_field_sum_unit_assert.svh]
// Assertion macros for the line segment field sum unit.
`ifndef LINE_SEGMENT_MAGNETIC_FIELD_SUM_UNIT_ASSERT_SVH
`define LINE_SEGMENT_MAGNETIC_FIELD_SUM_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LSMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define LSMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/lsmf_pkg.sv]
// Shared constants and types for the line segment field sum unit.
package lsmf_pkg;

  localparam int MAX_SEGMENTS    = 1024;
  localparam int ADDR_W          = $clog2(MAX_SEGMENTS);
  localparam int CNT_W           = $clog2(MAX_SEGMENTS + 1);
  localparam int COORD_FRAC_BITS = 24;
  localparam int OUT_FRAC        = 24;
  localparam int UNIT_BITS       = 28;
  localparam int DIR_BITS        = 30;
  localparam int SH_BASE         = DIR_BITS + UNIT_BITS - OUT_FRAC - COORD_FRAC_BITS;
  localparam int SEG_W           = 6 * 32;
  localparam int DIV_STEPS       = 64;
  localparam int SQRT_STEPS      = 32;

  localparam logic signed [63:0] ACC_HI  = 64'sh4000_0000_0000_0000;
  localparam logic signed [63:0] ACC_LO  = -64'sh4000_0000_0000_0000;
  localparam logic signed [63:0] F48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] F48_MIN = -64'sh0000_8000_0000_0000;
  localparam logic [62:0]        MAG2_MAX = '1;
  localparam logic [47:0]        SQ_LIMIT = 48'd3037000499;

  // Input actions
  localparam logic [1:0] ACT_STORE = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_FIELD   = 2'd0;
  localparam logic [1:0] ST_STORED  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  // Launch request for the divide / square-root unit
  typedef struct packed {
    logic go;
    logic sq;
  } dsu_ctl_t;

endpackage

[design/line_segment_magnetic_field_sum_unit.sv]
// Top level: segment store, query sequencer and field accumulation.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | action, ax, ay, az, bx_end, by_end, bz_end
//  result   | out_valid / out_ready| status, field_x/y/z, field_mag_squared
//
// Store and clear go from idle straight to posting their result. A query's work grows
// with the number N of stored segments (less for segments that add nothing); each segment
// costs ten 64-step divisions and three 32-step square roots on the one
// shared divide / square-root unit, plus short multiplier passes.
// Synchronous reset empties the store (fill count to zero); no clearing pass.
// in_ready is high only while the sequencer is idle; a query runs on while
// an earlier result waits at the output, then waits for that slot to free.
module line_segment_magnetic_field_sum_unit import lsmf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] az,
  input  logic signed [31:0] bx_end,
  input  logic signed [31:0] by_end,
  input  logic signed [31:0] bz_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [47:0] field_x,
  output logic signed [47:0] field_y,
  output logic signed [47:0] field_z,
  output logic [62:0]        field_mag_squared
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'b000_0000_0000_0000_0001,
    S_RD    = 19'b000_0000_0000_0000_0010,
    S_LOAD  = 19'b000_0000_0000_0000_0100,
    S_KSH   = 19'b000_0000_0000_0000_1000,
    S_CROSS = 19'b000_0000_0000_0001_0000,
    S_CMAG  = 19'b000_0000_0000_0010_0000,
    S_MSH   = 19'b000_0000_0000_0100_0000,
    S_NORM  = 19'b000_0000_0000_1000_0000,
    S_SQRT  = 19'b000_0000_0001_0000_0000,
    S_UNIT  = 19'b000_0000_0010_0000_0000,
    S_GDOT  = 19'b000_0000_0100_0000_0000,
    S_BMGO  = 19'b000_0000_1000_0000_0000,
    S_BM    = 19'b000_0001_0000_0000_0000,
    S_CHGO  = 19'b000_0010_0000_0000_0000,
    S_CH    = 19'b000_0100_0000_0000_0000,
    S_NEXT  = 19'b000_1000_0000_0000_0000,
    S_FIN   = 19'b001_0000_0000_0000_0000,
    S_MAG   = 19'b010_0000_0000_0000_0000,
    S_POST  = 19'b100_0000_0000_0000_0000
  } state_t;

  state_t state;

  logic [CNT_W-1:0] seg_count;
  logic [CNT_W-1:0] seg_idx;
  logic [CNT_W-1:0] seg_idx_next;

  logic signed [31:0] pt [3];
  logic [32:0] um [3];
  logic [32:0] vm [3];
  logic        us [3];
  logic        vs [3];
  logic [32:0] mx_sh;
  logic [2:0]  k;
  logic [30:0] sm [3];
  logic        ss [3];
  logic signed [59:0] cv [3];
  logic [58:0] cm [3];
  logic        cs [3];
  logic [58:0] mc_sh;
  logic [4:0]  m;
  logic [63:0] c2, u2, v2;
  logic [31:0] nc, nu, nv;
  logic [28:0] uh [3];
  logic [28:0] vh [3];
  logic signed [61:0] g;
  logic        gneg;
  logic [63:0] bm;
  logic [30:0] ch;
  logic [63:0] ph;
  logic signed [63:0] acc [3];
  logic signed [47:0] fld [3];
  logic [31:0] mag_a [3];
  logic        big;
  logic [62:0] msum;
  logic [62:0] mag2;
  logic [1:0]  pend_status;
  logic [3:0]  step;
  logic [1:0]  lane;
  logic        half;

  // Shared units
  logic [31:0] mul_a, mul_b;
  logic        mul_neg_in, mul_neg;
  logic [63:0] prod;
  dsu_ctl_t    dsu_ctl;
  logic [63:0] dsu_num;
  logic [31:0] dsu_den;
  logic        dsu_done;
  logic [63:0] dsu_res;

  // Store
  logic [SEG_W-1:0] rd_data;
  logic             ram_we;
  logic             in_xfer;
  logic             seg_room;

  // Combinational helpers
  logic signed [31:0] sa [3];
  logic signed [31:0] se [3];
  logic [32:0] du [3];
  logic [32:0] dv [3];
  logic [32:0] dum [3];
  logic [32:0] dvm [3];
  logic signed [30:0] ssum [3];
  logic [58:0] cmag [3];
  logic [61:0] gmag;
  logic [5:0]  sh_amt;
  logic [3:0]  qc;
  logic signed [59:0] spv60;
  logic signed [61:0] spv62;
  logic [1:0]  n_lane;
  logic        n_half;
  logic [63:0] pr;
  logic signed [63:0] ch_sum;
  logic signed [63:0] ch_sat;
  logic signed [63:0] fsat [3];
  logic [47:0] fmag [3];
  logic [63:0] mtmp;
  logic [62:0] msum_next;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign seg_room = seg_count < CNT_W'(MAX_SEGMENTS);
  assign ram_we   = in_xfer && (action == ACT_STORE) && seg_room;
  assign seg_idx_next = seg_idx + 1'b1;

  lsmf_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (seg_count[ADDR_W-1:0]),
    .wdata ({bz_end, by_end, bx_end, az, ay, ax}),
    .raddr (seg_idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  lsmf_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  lsmf_dsu u_dsu (
    .clk  (clk),
    .rst  (rst),
    .ctl  (dsu_ctl),
    .num  (dsu_num),
    .den  (dsu_den),
    .done (dsu_done),
    .res  (dsu_res)
  );

  // Per-axis differences, sums and magnitudes
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sa[j]  = rd_data[32*j +: 32];
      se[j]  = rd_data[96 + 32*j +: 32];
      du[j]  = {pt[j][31], pt[j]} - {sa[j][31], sa[j]};
      dv[j]  = {se[j][31], se[j]} - {pt[j][31], pt[j]};
      dum[j] = du[j][32] ? (33'd0 - du[j]) : du[j];
      dvm[j] = dv[j][32] ? (33'd0 - dv[j]) : dv[j];
      ssum[j] = (us[j] ? (31'sd0 - $signed(31'(um[j][28:0]))) : $signed(31'(um[j][28:0])))
              + (vs[j] ? (31'sd0 - $signed(31'(vm[j][28:0]))) : $signed(31'(vm[j][28:0])));
      cmag[j] = cv[j][59] ? 59'(60'sd0 - cv[j]) : cv[j][58:0];
      fsat[j] = (acc[j] > F48_MAX) ? F48_MAX : ((acc[j] < F48_MIN) ? F48_MIN : acc[j]);
      fmag[j] = fsat[j][63] ? 48'(64'sd0 - fsat[j]) : fsat[j][47:0];
    end
    gmag   = g[61] ? 62'(62'sd0 - g) : 62'(g);
    sh_amt = 6'(SH_BASE) + 6'(k) + 6'(m);
    qc     = step - 4'd1;
    spv60  = mul_neg ? (60'sd0 - $signed(prod[59:0])) : $signed(prod[59:0]);
    spv62  = mul_neg ? (62'sd0 - $signed(prod[61:0])) : $signed(prod[61:0]);
    n_lane = (lane == 2'd2) ? 2'd0 : lane + 2'd1;
    n_half = (lane == 2'd2) ? 1'b1 : half;
    pr     = ph + (prod >> DIR_BITS);
    ch_sum = acc[lane] + ((cs[lane] ^ gneg) ? (64'sd0 - $signed(pr)) : $signed(pr));
    ch_sat = (ch_sum > ACC_HI) ? ACC_HI : ((ch_sum < ACC_LO) ? ACC_LO : ch_sum);
    mtmp   = {1'b0, msum} + prod;
    msum_next = mtmp[63] ? MAG2_MAX : mtmp[62:0];
  end

  // Multiplier operand selection; the sign tag travels with the product
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    mul_neg_in = 1'b0;
    unique case (state)
      S_CROSS: begin
        unique case (step)
          4'd0: begin
            mul_a = 32'(vm[1][28:0]); mul_b = 32'(um[2][28:0]); mul_neg_in = vs[1] ^ us[2];
          end
          4'd1: begin
            mul_a = 32'(vm[2][28:0]); mul_b = 32'(um[1][28:0]); mul_neg_in = vs[2] ^ us[1];
          end
          4'd2: begin
            mul_a = 32'(vm[2][28:0]); mul_b = 32'(um[0][28:0]); mul_neg_in = vs[2] ^ us[0];
          end
          4'd3: begin
            mul_a = 32'(vm[0][28:0]); mul_b = 32'(um[2][28:0]); mul_neg_in = vs[0] ^ us[2];
          end
          4'd4: begin
            mul_a = 32'(vm[0][28:0]); mul_b = 32'(um[1][28:0]); mul_neg_in = vs[0] ^ us[1];
          end
          4'd5: begin
            mul_a = 32'(vm[1][28:0]); mul_b = 32'(um[0][28:0]); mul_neg_in = vs[1] ^ us[0];
          end
          default: begin
            mul_a = '0;
          end
        endcase
      end
      S_NORM: begin
        unique case (step)
          4'd0, 4'd1, 4'd2: begin
            mul_a = 32'(cm[step[1:0]][29:0]);
          end
          4'd3: mul_a = 32'(um[0][28:0]);
          4'd4: mul_a = 32'(um[1][28:0]);
          4'd5: mul_a = 32'(um[2][28:0]);
          4'd6: mul_a = 32'(vm[0][28:0]);
          4'd7: mul_a = 32'(vm[1][28:0]);
          4'd8: mul_a = 32'(vm[2][28:0]);
          default: mul_a = '0;
        endcase
        mul_b = mul_a;
      end
      S_GDOT: begin
        if (step < 4'd6) begin
          mul_a      = 32'(sm[step[2:1]]);
          mul_b      = step[0] ? 32'(vh[step[2:1]]) : 32'(uh[step[2:1]]);
          mul_neg_in = ss[step[2:1]] ^ (step[0] ? vs[step[2:1]] : us[step[2:1]]);
        end
      end
      S_CH: begin
        mul_a = 32'(ch);
        mul_b = (step == 4'd1) ? bm[61:30] : 32'(bm[29:0]);
      end
      S_MAG: begin
        if (step < 4'd3) begin
          mul_a = mag_a[step[1:0]];
          mul_b = mag_a[step[1:0]];
        end
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_neg <= mul_neg_in;
  end

  // Sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg_count <= '0;
      out_valid <= 1'b0;
      dsu_ctl   <= '0;
    end else begin
      dsu_ctl <= '0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            priority if (action == ACT_STORE) begin
              if (seg_room) begin
                seg_count <= seg_count + 1'b1;
              end
              state <= S_POST;
            end else if (action == ACT_CLEAR) begin
              seg_count <= '0;
              state     <= S_POST;
            end else begin
              state <= (seg_count == '0) ? S_FIN : S_RD;
            end
          end
        end
        S_RD:    state <= S_LOAD;
        S_LOAD:  state <= S_KSH;
        S_KSH:   if (mx_sh[32:29] == '0) state <= S_CROSS;
        S_CROSS: if (step == 4'd6) state <= S_CMAG;
        S_CMAG: begin
          state <= ((cmag[0] | cmag[1] | cmag[2]) == '0) ? S_NEXT : S_MSH;
        end
        S_MSH: begin
          if (mc_sh[58:30] == '0) state <= S_NORM;
        end
        S_NORM: begin
          if (step == 4'd9) begin
            dsu_ctl <= '{go: 1'b1, sq: 1'b1};
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (dsu_done) begin
            if (lane != 2'd2) begin
              dsu_ctl <= '{go: 1'b1, sq: 1'b1};
            end else if (nc == '0 || nu == '0 || dsu_res[31:0] == '0) begin
              state <= S_NEXT;
            end else begin
              dsu_ctl <= '{go: 1'b1, sq: 1'b0};
              state   <= S_UNIT;
            end
          end
        end
        S_UNIT: begin
          if (dsu_done) begin
            if (lane == 2'd2 && half) begin
              state <= S_GDOT;
            end else begin
              dsu_ctl <= '{go: 1'b1, sq: 1'b0};
            end
          end
        end
        S_GDOT: if (step == 4'd6) state <= S_BMGO;
        S_BMGO: begin
          dsu_ctl <= '{go: 1'b1, sq: 1'b0};
          state   <= S_BM;
        end
        S_BM:    if (dsu_done) state <= S_CHGO;
        S_CHGO: begin
          dsu_ctl <= '{go: 1'b1, sq: 1'b0};
          state   <= S_CH;
        end
        S_CH: begin
          if (step == 4'd3) state <= (lane == 2'd2) ? S_NEXT : S_CHGO;
        end
        S_NEXT:  state <= (seg_idx_next < seg_count) ? S_RD : S_FIN;
        S_FIN:   state <= S_MAG;
        S_MAG:   if (step == 4'd3) state <= S_POST;
        S_POST: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          for (int j = 0; j < 3; j++) begin
            fld[j] <= '0;
            acc[j] <= '0;
          end
          mag2    <= '0;
          seg_idx <= '0;
          pt[0]   <= ax;
          pt[1]   <= ay;
          pt[2]   <= az;
          priority if (action == ACT_STORE) begin
            pend_status <= seg_room ? ST_STORED : ST_FULL;
          end else if (action == ACT_CLEAR) begin
            pend_status <= ST_CLEARED;
          end else begin
            pend_status <= ST_FIELD;
          end
        end
      end
      S_LOAD: begin
        for (int j = 0; j < 3; j++) begin
          um[j] <= dum[j];
          vm[j] <= dvm[j];
          us[j] <= du[j][32];
          vs[j] <= dv[j][32];
        end
        mx_sh <= dum[0] | dum[1] | dum[2] | dvm[0] | dvm[1] | dvm[2];
        k     <= '0;
      end
      // Scale both difference vectors until they fit 29 bits
      S_KSH: begin
        if (mx_sh[32:29] != '0) begin
          for (int j = 0; j < 3; j++) begin
            um[j] <= um[j] >> 1;
            vm[j] <= vm[j] >> 1;
          end
          mx_sh <= mx_sh >> 1;
          k     <= k + 3'd1;
        end else begin
          for (int j = 0; j < 3; j++) begin
            sm[j] <= ssum[j][30] ? 31'(31'sd0 - ssum[j]) : 31'(ssum[j]);
            ss[j] <= ssum[j][30];
          end
          step <= '0;
        end
      end
      // Cross product v x u, two products per component
      S_CROSS: begin
        step <= step + 4'd1;
        if (step != 4'd0) begin
          if (!qc[0]) begin
            cv[qc[2:1]] <= spv60;
          end else begin
            cv[qc[2:1]] <= cv[qc[2:1]] - spv60;
          end
        end
      end
      S_CMAG: begin
        for (int j = 0; j < 3; j++) begin
          cm[j] <= cmag[j];
          cs[j] <= cv[j][59];
        end
        mc_sh <= cmag[0] | cmag[1] | cmag[2];
        m     <= '0;
      end
      // Scale the cross product until it fits 30 bits
      S_MSH: begin
        if (mc_sh[58:30] != '0) begin
          for (int j = 0; j < 3; j++) begin
            cm[j] <= cm[j] >> 1;
          end
          mc_sh <= mc_sh >> 1;
          m     <= m + 5'd1;
        end else begin
          step <= '0;
          c2   <= '0;
          u2   <= '0;
          v2   <= '0;
        end
      end
      // Squared lengths, then launch the first square root
      S_NORM: begin
        step <= step + 4'd1;
        if (step != 4'd0) begin
          priority if (qc < 4'd3) c2 <= c2 + prod;
          else if (qc < 4'd6) u2 <= u2 + prod;
          else v2 <= v2 + prod;
        end
        if (step == 4'd9) begin
          dsu_num <= c2;
          lane    <= '0;
        end
      end
      S_SQRT: begin
        if (dsu_done) begin
          unique case (lane)
            2'd0: begin
              nc      <= dsu_res[31:0];
              dsu_num <= u2;
            end
            2'd1: begin
              nu      <= dsu_res[31:0];
              dsu_num <= v2;
            end
            default: begin
              nv      <= dsu_res[31:0];
              dsu_num <= 64'(um[0][28:0]) << UNIT_BITS;
              dsu_den <= nu;
            end
          endcase
          lane <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
          half <= 1'b0;
        end
      end
      // Unit vectors of u and v
      S_UNIT: begin
        if (dsu_done) begin
          if (half) begin
            vh[lane] <= dsu_res[28:0];
          end else begin
            uh[lane] <= dsu_res[28:0];
          end
          lane    <= n_lane;
          half    <= n_half;
          dsu_num <= n_half ? (64'(vm[n_lane][28:0]) << UNIT_BITS)
                            : (64'(um[n_lane][28:0]) << UNIT_BITS);
          dsu_den <= n_half ? nv : nu;
          step    <= '0;
          g       <= '0;
        end
      end
      // g = S.uh + S.vh
      S_GDOT: begin
        step <= step + 4'd1;
        if (step != 4'd0) begin
          g <= g + spv62;
        end
      end
      S_BMGO: begin
        dsu_num <= 64'(gmag);
        dsu_den <= nc;
      end
      S_BM: begin
        if (dsu_done) begin
          bm   <= dsu_res >> sh_amt;
          gneg <= g[61];
          lane <= '0;
        end
      end
      S_CHGO: begin
        dsu_num <= 64'(cm[lane][29:0]) << DIR_BITS;
        dsu_den <= nc;
        step    <= '0;
      end
      // Direction component times magnitude, added with saturation
      S_CH: begin
        unique case (step)
          4'd0: begin
            if (dsu_done) begin
              ch   <= dsu_res[30:0];
              step <= 4'd1;
            end
          end
          4'd1: step <= 4'd2;
          4'd2: begin
            ph   <= prod;
            step <= 4'd3;
          end
          default: begin
            acc[lane] <= ch_sat;
            lane      <= lane + 2'd1;
          end
        endcase
      end
      S_NEXT: begin
        seg_idx <= seg_idx_next;
      end
      // Saturate to 48 bits and prepare the squared magnitude
      S_FIN: begin
        for (int j = 0; j < 3; j++) begin
          fld[j]   <= fsat[j][47:0];
          mag_a[j] <= fmag[j][31:0];
        end
        big  <= (fmag[0] > SQ_LIMIT) || (fmag[1] > SQ_LIMIT) || (fmag[2] > SQ_LIMIT);
        msum <= '0;
        step <= '0;
      end
      S_MAG: begin
        step <= step + 4'd1;
        if (step != 4'd0) begin
          msum <= msum_next;
        end
        if (step == 4'd3) begin
          mag2 <= big ? MAG2_MAX : msum_next;
        end
      end
      default: begin
        step <= step;
      end
    endcase
  end

  // Output register, loaded when the slot is free
  always_ff @(posedge clk) begin
    if (state == S_POST && (!out_valid || out_ready)) begin
      status            <= pend_status;
      field_x           <= fld[0];
      field_y           <= fld[1];
      field_z           <= fld[2];
      field_mag_squared <= mag2;
    end
  end

  `include "line_segment_magnetic_field_sum_unit_assert.svh"

  `LSMF_ASSERT_NOW(a_cnt_bound, 1'b1, seg_count <= CNT_W'(MAX_SEGMENTS), "segment count overflow")
  `LSMF_ASSERT_NEXT(a_cnt_hold, state != S_IDLE, $stable(seg_count), "count changed mid-item")
  `LSMF_ASSERT_NOW(a_out_from_post, $rose(out_valid), $past(state == S_POST), "result not from post")
  `LSMF_ASSERT_NOW(a_dsu_wait, dsu_done, (state == S_SQRT) || (state == S_UNIT) || (state == S_BM) || (state == S_CH), "unit done outside a wait state")

endmodule

[design/lsmf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lsmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/lsmf_mul.sv]
// Shared 32x32 unsigned multiplier with a registered product.
module lsmf_mul import lsmf_pkg::*; (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= {32'd0, op_a} * {32'd0, op_b};
  end

endmodule

[design/lsmf_dsu.sv]
// Shared iterative unit: restoring divide (one quotient bit a cycle) or
// integer square root (one result bit a cycle).
module lsmf_dsu import lsmf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dsu_ctl_t    ctl,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] res
);

  logic        busy;
  logic        sq;
  logic [5:0]  cnt;
  logic [63:0] ra;    // dividend/quotient, or remaining radicand
  logic [63:0] rb;    // partial remainder, or root
  logic [63:0] bitv;
  logic [31:0] dn;

  logic [32:0] rsh;
  logic        dfit;
  logic [32:0] rdiff;
  logic [63:0] tsum;
  logic        sfit;

  // One compare-subtract per cycle for either operation
  always_comb begin
    rsh   = {rb[31:0], ra[63]};
    dfit  = rsh >= {1'b0, dn};
    rdiff = rsh - {1'b0, dn};
    tsum  = rb + bitv;
    sfit  = ra >= tsum;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      sq   <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.go) begin
        busy <= 1'b1;
        sq   <= ctl.sq;
        cnt  <= ctl.sq ? 6'(SQRT_STEPS - 1) : 6'(DIV_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctl.go) begin
      ra   <= num;
      rb   <= '0;
      bitv <= 64'h4000_0000_0000_0000;
      dn   <= den;
    end else if (busy) begin
      if (sq) begin
        if (sfit) begin
          ra <= ra - tsum;
          rb <= (rb >> 1) + bitv;
        end else begin
          rb <= rb >> 1;
        end
        bitv <= bitv >> 2;
      end else begin
        ra <= {ra[62:0], dfit};
        rb <= dfit ? 64'(rdiff) : 64'(rsh);
      end
    end
  end

  assign res = sq ? rb : ra;

endmodule
